// ----- design/crc16rx_pkg.sv -----
// Package for the CRC-16 response frame receiver.
// Holds the item and result types, the command codes and the CRC constants.
// No dependencies.
package crc16rx_pkg;

  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [7:0]  RESPONSE_TYPE = 8'hFF;
  localparam logic [8:0]  COUNT_MAX     = 9'd511;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_MASTER_ADDRESS   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_CAPACITY = 8'd1;

  typedef enum logic [1:0] {
    FUNC_BYTE   = 2'd0,
    FUNC_ARM    = 2'd1,
    FUNC_DISARM = 2'd2
  } func_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_valid;
    logic [7:0] stored_length;
  } result_t;

endpackage

// ----- design/crc16rx_crc.sv -----
// One-byte update of the reflected CRC-16 (polynomial 0xA001).
// Depends on crc16rx_pkg.
module crc16rx_crc
  import crc16rx_pkg::*;
(
  input  logic [15:0] crc,
  input  logic [7:0]  data,
  output logic [15:0] crc_next
);

  always_comb begin
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_next = c;
  end

endmodule

// ----- design/crc16rx_frame.sv -----
// Frame state and per-item result logic: counters, held CRC bytes, running CRC.
// Depends on crc16rx_pkg and crc16rx_crc.
module crc16rx_frame
  import crc16rx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  item_t      item,
  input  logic [7:0] master_address,
  input  logic [7:0] payload_capacity,
  output result_t    result
);

  logic        receiving, receiving_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [7:0]  dest_address, dest_address_next;
  logic [7:0]  message_type, message_type_next;
  logic [7:0]  held0, held0_next;
  logic [7:0]  held1, held1_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  payload_count, payload_count_next;

  logic [7:0]  crc_data;
  logic [15:0] crc_upd;
  logic [8:0]  count_inc;

  assign count_inc = (byte_count < COUNT_MAX) ? byte_count + 9'd1 : byte_count;
  // first two bytes feed the CRC directly, later ones feed the oldest held byte
  assign crc_data  = (count_inc == 9'd1 || count_inc == 9'd2) ? item.data_byte : held0;

  crc16rx_crc u_crc (
    .crc      (running_crc),
    .data     (crc_data),
    .crc_next (crc_upd)
  );

  always_comb begin
    receiving_next     = receiving;
    byte_count_next    = byte_count;
    dest_address_next  = dest_address;
    message_type_next  = message_type;
    held0_next         = held0;
    held1_next         = held1;
    running_crc_next   = running_crc;
    payload_count_next = payload_count;
    result             = '0;

    case (item.func)
      FUNC_ARM: begin
        receiving_next     = 1'b1;
        byte_count_next    = '0;
        payload_count_next = '0;
        dest_address_next  = '0;
        message_type_next  = '0;
        held0_next         = '0;
        held1_next         = '0;
        running_crc_next   = CRC_INIT;
      end
      FUNC_DISARM: begin
        receiving_next = 1'b0;
      end
      FUNC_BYTE: begin
        if (receiving && (payload_count < payload_capacity)) begin
          result.accepted = 1'b1;
          byte_count_next = count_inc;
          if (count_inc == 9'd1) begin
            dest_address_next = item.data_byte;
            running_crc_next  = crc_upd;
          end else if (count_inc == 9'd2) begin
            message_type_next = item.data_byte;
            running_crc_next  = crc_upd;
          end else if (count_inc == 9'd3) begin
            held0_next = item.data_byte;
          end else begin
            if (count_inc == 9'd4) begin
              held1_next = item.data_byte;
            end else begin
              result.payload_valid = 1'b1;
              result.payload_byte  = held0;
              result.payload_index = payload_count;
              running_crc_next     = crc_upd;
              payload_count_next   = payload_count + 8'd1;
              held0_next           = held1;
              held1_next           = item.data_byte;
            end
            result.frame_valid = (dest_address == master_address) &&
                                 (message_type == RESPONSE_TYPE) &&
                                 (running_crc_next == {held1_next, held0_next});
          end
        end
      end
      default: begin
      end
    endcase

    result.stored_length = payload_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving     <= 1'b0;
      byte_count    <= '0;
      dest_address  <= '0;
      message_type  <= '0;
      held0         <= '0;
      held1         <= '0;
      running_crc   <= CRC_INIT;
      payload_count <= '0;
    end else if (fire) begin
      receiving     <= receiving_next;
      byte_count    <= byte_count_next;
      dest_address  <= dest_address_next;
      message_type  <= message_type_next;
      held0         <= held0_next;
      held1         <= held1_next;
      running_crc   <= running_crc_next;
      payload_count <= payload_count_next;
    end
  end

endmodule

// ----- design/crc16_response_frame_receiver_core.sv -----
// CRC-16 response frame receiver, top level.
// An accepted item moves through the input register, then the result register.
// One item per cycle unless result_stall holds; CRC and frame state update on advance.
// Reset (rst, synchronous, active high): empties both item registers, stops reception,
// clears counters and held bytes, sets the running CRC to 0xFFFF and the registers to defaults.
module crc16_response_frame_receiver_core
  import crc16rx_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // item channel
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  // result channel
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  // configuration registers
  logic [7:0] master_address;
  logic [7:0] payload_capacity;

  // input register
  logic    stage_valid;
  item_t   stage_item;

  // frame logic result for the item in the input register
  result_t step_result;
  logic    advance;

  // The item in the input register moves into the result register when that
  // one is empty or is being taken this cycle.
  assign advance    = stage_valid && (!result_valid || !result_stall);
  // A new item may enter whenever the input register empties or is free.
  assign item_stall = stage_valid && !advance;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_address   <= 8'd0;
      payload_capacity <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MASTER_ADDRESS:   master_address   <= cfg_data;
        REG_PAYLOAD_CAPACITY: payload_capacity <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register: payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage_item <= item;
    end
  end

  // frame state is updated exactly when the item's result is registered
  crc16rx_frame u_frame (
    .clk              (clk),
    .rst              (rst),
    .fire             (advance),
    .item             (stage_item),
    .master_address   (master_address),
    .payload_capacity (payload_capacity),
    .result           (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

endmodule
